// ----- src/pmlsf_pkg.sv -----
// Package for the split-field PML cell update pipeline.
// Holds register codes, field codes, fixed-point constants and the stage payload.
// No dependencies.
package pmlsf_pkg;

  localparam int NUM_REGS      = 7;
  localparam int ADDR_W        = 5;
  localparam int SERIES_TERMS  = 12;
  localparam int SERIES_STEPS  = SERIES_TERMS - 1;
  localparam int EXP_STEPS     = 31;
  localparam int QUOT_BITS     = 31;
  localparam int RECIP_SHIFT   = 35;

  typedef enum logic [2:0] {
    REG_DECAY_RATE = 3'd0,
    REG_CELL_X     = 3'd1,
    REG_CELL_Y     = 3'd2,
    REG_CELL_Z     = 3'd3,
    REG_DGAIN_X    = 3'd4,
    REG_DGAIN_Y    = 3'd5,
    REG_DGAIN_Z    = 3'd6
  } reg_idx_t;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;
  localparam logic       KIND_E    = 1'b0;
  localparam logic       KIND_B    = 1'b1;

  localparam logic [32:0] ONE_Q32         = 33'h1_0000_0000;
  localparam logic [30:0] EXP_NEG_ONE_Q32 = 31'd1580030169;
  localparam logic [31:0] GAIN_MAX        = 32'h7FFF_FFFF;

  // floor(2^35 / k) for the series divisors 2..12
  localparam logic [34:0] RECIP_TAB [SERIES_TERMS+1] = '{
    35'd0, 35'd0,
    35'd17179869184, 35'd11453246122, 35'd8589934592, 35'd6871947673,
    35'd5726623061,  35'd4908534052,  35'd4294967296, 35'd3817748707,
    35'd3435973836,  35'd3123612578,  35'd2863311530
  };

  typedef struct packed {
    logic [31:0] decay_rate;
    logic [31:0] cell_size_x;
    logic [31:0] cell_size_y;
    logic [31:0] cell_size_z;
    logic [31:0] default_gain_x;
    logic [31:0] default_gain_y;
    logic [31:0] default_gain_z;
  } cfg_t;

  typedef struct packed {
    logic               bypass;
    logic               sig_zero;
    logic               first_plus;
    logic               big;
    logic [4:0]         n;
    logic [31:0]        y;
    logic [32:0]        s;
    logic [31:0]        term;
    logic [31:0]        prod;
    logic [31:0]        quo;
    logic [63:0]        den;
    logic signed [31:0] defg;
    logic [16:0]        d;
    logic [63:0]        rem;
    logic [30:0]        nlow;
    logic               ovf;
    logic [30:0]        q;
    logic signed [31:0] old1;
    logic signed [31:0] old2;
    logic signed [32:0] diff1;
    logic signed [32:0] diff2;
  } item_t;

endpackage

// ----- src/pmlsf_regs.sv -----
// Configuration register file on an APB-style port.
// Depends on pmlsf_pkg.
module pmlsf_regs
  import pmlsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_rate     <= 32'd0;
      cfg.cell_size_x    <= 32'd65536;
      cfg.cell_size_y    <= 32'd65536;
      cfg.cell_size_z    <= 32'd65536;
      cfg.default_gain_x <= 32'd0;
      cfg.default_gain_y <= 32'd0;
      cfg.default_gain_z <= 32'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_DECAY_RATE: cfg.decay_rate     <= pwdata;
        REG_CELL_X:     cfg.cell_size_x    <= pwdata;
        REG_CELL_Y:     cfg.cell_size_y    <= pwdata;
        REG_CELL_Z:     cfg.cell_size_z    <= pwdata;
        REG_DGAIN_X:    cfg.default_gain_x <= pwdata;
        REG_DGAIN_Y:    cfg.default_gain_y <= pwdata;
        REG_DGAIN_Z:    cfg.default_gain_z <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DECAY_RATE: prdata = cfg.decay_rate;
      REG_CELL_X:     prdata = cfg.cell_size_x;
      REG_CELL_Y:     prdata = cfg.cell_size_y;
      REG_CELL_Z:     prdata = cfg.cell_size_z;
      REG_DGAIN_X:    prdata = cfg.default_gain_x;
      REG_DGAIN_Y:    prdata = cfg.default_gain_y;
      REG_DGAIN_Z:    prdata = cfg.default_gain_z;
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ----- src/pmlsf_exp.sv -----
// Decay pipeline: series for the fractional exponent, then one exp(-1) step per stage.
// Depends on pmlsf_pkg.
module pmlsf_exp
  import pmlsf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_vld,
  input  item_t in_item,
  output logic  out_vld,
  output item_t out_item
);

  localparam int NS = 1 + 3*SERIES_STEPS + EXP_STEPS;

  item_t          st [NS];
  item_t          nx [NS];
  logic [NS-1:0]  vld;

  always_comb begin
    logic [35:0] rem;
    logic [31:0] fix;
    logic [63:0] pr;
    logic [66:0] pq;
    nx[0]      = in_item;
    nx[0].s    = ONE_Q32 - {1'b0, in_item.y};
    nx[0].term = in_item.y;
    for (int i = 1; i < NS; i++) nx[i] = st[i-1];
    for (int j = 0; j < SERIES_STEPS; j++) begin
      pr = 64'(st[3*j].term) * 64'(st[3*j].y);
      nx[3*j+1].prod = pr[63:32];
      pq = 67'(st[3*j+1].prod) * 67'(RECIP_TAB[j+2]);
      nx[3*j+2].quo = pq[RECIP_SHIFT +: 32];
      rem = 36'(st[3*j+2].prod) - 36'(st[3*j+2].quo) * 36'(j+2);
      fix = st[3*j+2].quo + ((rem >= 36'(j+2)) ? 32'd1 : 32'd0);
      nx[3*j+3].term = fix;
      if (((j+2) % 2) == 1) nx[3*j+3].s = st[3*j+2].s - {1'b0, fix};
      else                  nx[3*j+3].s = st[3*j+2].s + {1'b0, fix};
    end
    for (int j = 0; j < EXP_STEPS; j++) begin
      pr = 64'(st[3*SERIES_STEPS+j].s) * 64'(EXP_NEG_ONE_Q32) + 64'h8000_0000;
      if (5'(j) < st[3*SERIES_STEPS+j].n) nx[3*SERIES_STEPS+j+1].s = pr[64-1:31+1] > 0 ?
        33'(pr[63:32]) : 33'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) st[i] <= nx[i];
    end
  end

  assign out_vld  = vld[NS-1];
  assign out_item = st[NS-1];

endmodule

// ----- src/pmlsf_div.sv -----
// Gain divider: forms the rounded numerator, flags overflow, one quotient bit per stage.
// Depends on pmlsf_pkg.
module pmlsf_div
  import pmlsf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_vld,
  input  item_t in_item,
  output logic  out_vld,
  output item_t out_item
);

  localparam int NS = 1 + QUOT_BITS;

  item_t          st [NS];
  item_t          nx [NS];
  logic [NS-1:0]  vld;

  always_comb begin
    logic [32:0] sf;
    logic [33:0] dr;
    logic [32:0] num;
    logic [64:0] nn;
    logic [64:0] r2;
    sf  = in_item.big ? 33'd0 : in_item.s;
    dr  = {1'b0, sf} + 34'd32768;
    num = ONE_Q32 - sf;
    nn  = 65'({num, 16'd0}) + 65'(in_item.den >> 1);
    nx[0]      = in_item;
    nx[0].d    = dr[32:16];
    nx[0].ovf  = 64'(nn[64:31]) >= in_item.den;
    nx[0].rem  = 64'(nn[64:31]);
    nx[0].nlow = nn[30:0];
    nx[0].q    = '0;
    for (int i = 1; i < NS; i++) nx[i] = st[i-1];
    for (int j = 0; j < QUOT_BITS; j++) begin
      r2 = {st[j].rem, st[j].nlow[QUOT_BITS-1-j]};
      if (r2 >= {1'b0, st[j].den}) begin
        nx[j+1].rem = 64'(r2 - {1'b0, st[j].den});
        nx[j+1].q[QUOT_BITS-1-j] = 1'b1;
      end else begin
        nx[j+1].rem = r2[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) st[i] <= nx[i];
    end
  end

  assign out_vld  = vld[NS-1];
  assign out_item = st[NS-1];

endmodule

// ----- src/pmlsf_out.sv -----
// Output stages: decay and gain products, then rounding, sum and saturation.
// Depends on pmlsf_pkg.
module pmlsf_out
  import pmlsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  item_t              in_item,
  output logic               out_vld,
  output logic signed [31:0] first_split_new,
  output logic signed [31:0] second_split_new
);

  logic               vld1;
  logic               plus1, bypass1;
  logic signed [31:0] old1, old2;
  logic signed [49:0] pa1, pa2;
  logic signed [64:0] pb1, pb2;
  logic signed [31:0] g;
  logic signed [17:0] dd;

  function automatic logic signed [31:0] combine(logic signed [49:0] pa,
                                                 logic signed [64:0] pb,
                                                 logic plus);
    logic signed [49:0] ar;
    logic signed [64:0] br;
    logic signed [50:0] sum;
    ar  = (pa + 50'sd32768) >>> 16;
    br  = (pb + 65'sd32768) >>> 16;
    sum = plus ? 51'(ar) + 51'(br) : 51'(ar) - 51'(br);
    if (sum > 51'sd2147483647)       return 32'sh7FFF_FFFF;
    else if (sum < -51'sd2147483648) return 32'sh8000_0000;
    else                             return 32'(sum);
  endfunction

  always_comb begin
    if (in_item.sig_zero)  g = in_item.defg;
    else if (in_item.ovf)  g = signed'(GAIN_MAX);
    else                   g = signed'({1'b0, in_item.q});
    dd = in_item.sig_zero ? 18'sd65536 : signed'({1'b0, in_item.d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plus1   <= in_item.first_plus;
      bypass1 <= in_item.bypass;
      old1    <= in_item.old1;
      old2    <= in_item.old2;
      pa1     <= 50'(in_item.old1) * 50'(dd);
      pa2     <= 50'(in_item.old2) * 50'(dd);
      pb1     <= 65'(g) * 65'(in_item.diff1);
      pb2     <= 65'(g) * 65'(in_item.diff2);
      first_split_new  <= bypass1 ? old1 : combine(pa1, pb1, plus1);
      second_split_new <= bypass1 ? old2 : combine(pa2, pb2, !plus1);
    end
  end

endmodule

// ----- src/pml_split_field_cell_update.sv -----
// Top level of the split-field PML cell update: front stage, decay, gain divider, output.
// Depends on pmlsf_pkg, pmlsf_regs, pmlsf_exp, pmlsf_div, pmlsf_out.
//
//   channel   signals                                   transfer when
//   config    psel penable pwrite paddr pwdata prdata    psel & penable & pwrite & pready
//   item      item_valid item_stall + 9 fields          item_valid & !item_stall
//   result    result_valid result_stall + 2 fields      result_valid & !result_stall
//
// One cell enters per cycle while the pipe is not held; stages: 1 front stage, 65 decay stages
// (series, then one exp(-1) multiply per stage), 32 divider stages (one quotient bit each), 2 out.
// The whole pipe advances together; it holds when a result waits under result_stall.
// Synchronous reset clears all valid bits and loads register defaults.
module pml_split_field_cell_update
  import pmlsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               kind,
  input  logic [1:0]         axis,
  input  logic [31:0]        sigma,
  input  logic signed [31:0] first_split_old,
  input  logic signed [31:0] second_split_old,
  input  logic signed [31:0] first_drive_here,
  input  logic signed [31:0] first_drive_near,
  input  logic signed [31:0] second_drive_here,
  input  logic signed [31:0] second_drive_near,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] first_split_new,
  output logic signed [31:0] second_split_new
);

  cfg_t        cfg;
  logic        en;
  logic        vld0, vld_e, vld_d;
  item_t       it0, it_nx, it_e, it_d;
  logic [31:0] cell_size;
  logic [63:0] tp;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  pmlsf_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  always_comb begin
    case (axis)
      AXIS_X:  cell_size = cfg.cell_size_x;
      AXIS_Y:  cell_size = cfg.cell_size_y;
      default: cell_size = cfg.cell_size_z;
    endcase
    tp    = 64'(sigma) * 64'(cfg.decay_rate);
    it_nx = '0;
    case (axis)
      AXIS_X:  it_nx.defg = signed'(cfg.default_gain_x);
      AXIS_Y:  it_nx.defg = signed'(cfg.default_gain_y);
      default: it_nx.defg = signed'(cfg.default_gain_z);
    endcase
    it_nx.bypass   = (axis == AXIS_NONE);
    it_nx.sig_zero = (sigma == 32'd0);
    it_nx.big      = |tp[63:37];
    it_nx.n        = tp[36:32];
    it_nx.y        = {tp[31:16], 16'd0};
    it_nx.den      = 64'(sigma) * 64'(cell_size);
    it_nx.old1     = first_split_old;
    it_nx.old2     = second_split_old;
    if (kind == KIND_B) begin
      it_nx.diff1      = 33'(first_drive_near) - 33'(first_drive_here);
      it_nx.diff2      = 33'(second_drive_near) - 33'(second_drive_here);
      it_nx.first_plus = (axis != AXIS_Y);
    end else begin
      it_nx.diff1      = 33'(first_drive_here) - 33'(first_drive_near);
      it_nx.diff2      = 33'(second_drive_here) - 33'(second_drive_near);
      it_nx.first_plus = (axis == AXIS_Y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0 <= it_nx;
    end
  end

  pmlsf_exp u_exp (
    .clk, .rst, .en, .in_vld(vld0), .in_item(it0), .out_vld(vld_e), .out_item(it_e)
  );

  pmlsf_div u_div (
    .clk, .rst, .en, .in_vld(vld_e), .in_item(it_e), .out_vld(vld_d), .out_item(it_d)
  );

  pmlsf_out u_out (
    .clk, .rst, .en, .in_vld(vld_d), .in_item(it_d), .out_vld(result_valid),
    .first_split_new, .second_split_new
  );

endmodule

// ----- src/pmlsf_chk.sv -----
// Port checker for the split-field PML cell update, with its bind.
// Depends on pml_split_field_cell_update.
module pmlsf_chk (
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] first_split_new,
  input logic [31:0] second_split_new
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled without a blocked result");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped under stall");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(first_split_new) && $stable(second_split_new))
    else $error("result changed under stall");

endmodule

bind pml_split_field_cell_update pmlsf_chk u_chk (
  .clk, .rst, .item_stall, .result_valid, .result_stall, .first_split_new, .second_split_new
);

// ----- verif/testbench.sv -----
// Self-checking bench for the split-field PML cell update pipeline.
// Predicts each updated split pair in Q16.16 and compares every result transfer.
// Depends on pmlsf_pkg and pml_split_field_cell_update.
module testbench;
  import pmlsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              kind;
    logic [1:0]        axis;
    logic [31:0]       sigma;
    logic signed [31:0] old1, old2, h1, n1, h2, n2;
  } cell_t;

  typedef struct {
    logic signed [31:0] first_new;
    logic signed [31:0] second_new;
  } split_pair_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic item_valid = 0, item_stall;
  logic kind = 0;
  logic [1:0] axis = '0;
  logic [31:0] sigma = '0;
  logic signed [31:0] first_split_old = 0, second_split_old = 0;
  logic signed [31:0] first_drive_here = 0, first_drive_near = 0;
  logic signed [31:0] second_drive_here = 0, second_drive_near = 0;
  logic result_valid, result_stall = 0;
  logic signed [31:0] first_split_new, second_split_new;

  logic [31:0] regs [NUM_REGS] = '{32'd0, 32'd65536, 32'd65536, 32'd65536,
                                   32'd0, 32'd0, 32'd0};
  split_pair_t pending_splits[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;

  pml_split_field_cell_update dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [63:0] exp_neg_q32(logic [63:0] t);
    logic [63:0] n, y, term, s;
    n = t >> 16;
    y = (t & 64'hFFFF) << 16;
    term = 64'h1_0000_0000;
    s = term;
    if (n >= 32) return 0;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 32) / k;
      if (k % 2) s = s - term;
      else s = s + term;
    end
    for (int k = 0; k < n; k++) s = (s * 64'd1580030169 + 64'h8000_0000) >> 32;
    return s;
  endfunction

  function automatic longint round_q16(longint v);
    longint x;
    x = v + 32768;
    if (x >= 0) return x >>> 16;
    return -((-x + 65535) >>> 16);
  endfunction

  function automatic logic [31:0] sat_sum(longint a, longint b, bit plus);
    longint v;
    v = plus ? a + b : a - b;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic split_pair_t update_split_pair(cell_t c);
    split_pair_t r;
    logic [63:0] s, num, den, q, cs;
    longint d, g, diff1, diff2;
    bit plus;
    if (c.axis == AXIS_NONE) begin
      r.first_new = c.old1;
      r.second_new = c.old2;
      return r;
    end
    cs = regs[REG_CELL_X + c.axis];
    if (c.sigma == 0) begin
      d = 65536;
      g = $signed(regs[REG_DGAIN_X + c.axis]);
    end else begin
      s = exp_neg_q32((64'(c.sigma) * 64'(regs[REG_DECAY_RATE])) >> 16);
      num = 64'h1_0000_0000 - s;
      den = 64'(c.sigma) * cs;
      d = longint'((s + 32768) >> 16);
      if (den == 0) q = 64'h7FFF_FFFF;
      else begin
        q = ((num << 16) + den / 2) / den;
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      end
      g = longint'(q);
    end
    if (c.kind == KIND_B) begin
      diff1 = longint'(c.n1) - longint'(c.h1);
      diff2 = longint'(c.n2) - longint'(c.h2);
      plus = c.axis != AXIS_Y;
    end else begin
      diff1 = longint'(c.h1) - longint'(c.n1);
      diff2 = longint'(c.h2) - longint'(c.n2);
      plus = c.axis == AXIS_Y;
    end
    r.first_new = sat_sum(round_q16(longint'(c.old1) * d), round_q16(g * diff1), plus);
    r.second_new = sat_sum(round_q16(longint'(c.old2) * d), round_q16(g * diff2), !plus);
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= ADDR_W'(4 * idx); pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    regs[idx] = value;
  endtask

  task automatic drain;
    while (pending_splits.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_cell(cell_t c);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    kind <= c.kind; axis <= c.axis; sigma <= c.sigma;
    first_split_old <= c.old1; second_split_old <= c.old2;
    first_drive_here <= c.h1; first_drive_near <= c.n1;
    second_drive_here <= c.h2; second_drive_near <= c.n2;
    do @(posedge clk); while (item_stall);
    pending_splits.push_back(update_split_pair(c));
  endtask

  task automatic end_burst;
    item_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(131072)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c.kind = 1'($urandom_range(1));
    c.axis = ($urandom_range(15) == 0) ? AXIS_NONE : 2'($urandom_range(2));
    case ($urandom_range(5))
      0: c.sigma = 32'd0;
      1: c.sigma = $urandom;
      2: c.sigma = 32'($urandom_range(1, 65536));
      default: c.sigma = 32'($urandom_range(1, 65536 * 8));
    endcase
    c.old1 = rand_word(); c.old2 = rand_word();
    c.h1 = rand_word(); c.n1 = rand_word();
    c.h2 = rand_word(); c.n2 = rand_word();
    return c;
  endfunction

  always @(posedge clk) begin
    split_pair_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_splits.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = pending_splits.pop_front();
        if (first_split_new !== want.first_new) begin
          $error("first_split_new expected %h got %h", want.first_new, first_split_new);
          errors++;
        end
        if (second_split_new !== want.second_new) begin
          $error("second_split_new expected %h got %h", want.second_new, second_split_new);
          errors++;
        end
      end
    end
    result_stall <= hold_off || (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed_extremes;
    cell_t c;
    logic [31:0] sig_set [4] = '{32'd0, 32'd1, 32'd65536, 32'hFFFF_FFFF};
    write_reg(REG_DECAY_RATE, 32'd65536);
    write_reg(REG_DGAIN_X, 32'h0001_0000);
    write_reg(REG_DGAIN_Y, 32'h8000_0000);
    write_reg(REG_DGAIN_Z, 32'h7FFF_FFFF);
    for (int i = 0; i < 24; i++) begin
      c.kind = i[0];
      c.axis = 2'(i / 2 % 4);
      c.sigma = sig_set[i / 8 % 4 + (i % 3 == 0 ? 0 : 0)];
      if (i >= 16) c.sigma = sig_set[i % 4];
      c.old1 = i[1] ? 32'h7FFF_FFFF : 32'h8000_0000;
      c.old2 = i[2] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      c.h1 = 32'h7FFF_FFFF; c.n1 = 32'h8000_0000;
      c.h2 = 32'h8000_0000; c.n2 = 32'h7FFF_FFFF;
      send_cell(c);
    end
    end_burst();
    drain();
  endtask

  task automatic test_config_extremes;
    write_reg(REG_DECAY_RATE, 32'h0);
    write_reg(REG_CELL_X, 32'h0);
    write_reg(REG_CELL_Y, 32'hFFFF_FFFF);
    write_reg(REG_CELL_Z, 32'd1);
    for (int i = 0; i < 12; i++) send_cell(rand_cell());
    end_burst();
    drain();
    write_reg(REG_DECAY_RATE, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) send_cell(rand_cell());
    end_burst();
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_cell(rand_cell());
    end_burst();
    drain();
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 150; i++) send_cell(rand_cell());
    join
    end_burst();
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    test_directed_extremes();
    test_config_extremes();
    write_reg(REG_DECAY_RATE, 32'd6554);
    write_reg(REG_CELL_X, 32'd65536);
    write_reg(REG_CELL_Y, 32'd32768);
    write_reg(REG_CELL_Z, 32'd131072);
    write_reg(REG_DGAIN_X, $urandom);
    write_reg(REG_DGAIN_Y, 32'd0);
    write_reg(REG_DGAIN_Z, 32'hFFFF_0000);
    send_idle_pct = 22; recv_stall_pct = 81;
    test_random(200);
    send_idle_pct = 81; recv_stall_pct = 22;
    write_reg(REG_DECAY_RATE, 32'd70000);
    test_random(200);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_backpressure();
    write_reg(REG_DECAY_RATE, $urandom);
    test_random(100);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- filelist.f -----
src/pmlsf_pkg.sv
src/pmlsf_regs.sv
src/pmlsf_exp.sv
src/pmlsf_div.sv
src/pmlsf_out.sv
src/pml_split_field_cell_update.sv
src/pmlsf_chk.sv
verif/testbench.sv
